// ===== design/mbrm_pkg.sv =====
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU
// read master. Used by mbrm_rx_parse and modbus_rtu_read_master_frame.
`default_nettype none

package mbrm_pkg;

  // Response buffer limit: bytes at or beyond this index are neither counted nor parsed.
  localparam int RX_MAX   = 512;
  localparam int RX_IDX_W = $clog2(RX_MAX + 1);
  // Width for comparing a frame position against the 8-bit byte count
  localparam int CMP_W    = (RX_IDX_W > 8) ? RX_IDX_W : 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic ACT_REQUEST  = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_EXCEPTION = 2'd2;

  typedef struct packed {
    logic        action;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  rx_byte;
    logic        rx_final;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [1:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } out_item_t;

  // Control from the top level into the response parser
  typedef struct packed {
    logic       step;      // take one response byte
    logic       clear;     // new request: drop response state
    logic [7:0] rx_byte;
    logic       rx_final;
  } rx_ctl_t;

  // What one response byte yields
  typedef struct packed {
    logic        has_val;
    logic [15:0] val;
    logic [1:0]  status;
    logic [7:0]  exc_code;
  } rx_res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/mbrm_rx_parse.sv =====
// Response byte parser: position tracking, exception flag, byte count and
// value pair assembly. Depends on mbrm_pkg.
`default_nettype none

module mbrm_rx_parse
  import mbrm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire rx_ctl_t ctl,
  output rx_res_t      res
);

  logic [RX_IDX_W-1:0] rx_index, rx_index_next;
  logic                exception_seen, exception_seen_next;
  logic [7:0]          byte_count, byte_count_next;
  logic [7:0]          high_byte_hold, high_byte_hold_next;
  logic [7:0]          exception_hold, exception_hold_next;

  logic [RX_IDX_W-1:0] pos;

  always_comb begin
    rx_index_next       = rx_index;
    exception_seen_next = exception_seen;
    byte_count_next     = byte_count;
    high_byte_hold_next = high_byte_hold;
    exception_hold_next = exception_hold;
    res                 = '0;
    pos                 = rx_index - RX_IDX_W'(3);

    if (rx_index < RX_IDX_W'(RX_MAX)) begin
      if (rx_index == RX_IDX_W'(1)) begin
        exception_seen_next = ctl.rx_byte[7];
      end else if (rx_index == RX_IDX_W'(2)) begin
        byte_count_next     = ctl.rx_byte;
        exception_hold_next = ctl.rx_byte;
      end else if (rx_index >= RX_IDX_W'(3) && !exception_seen) begin
        if (!pos[0]) begin
          if (CMP_W'(pos) < CMP_W'(byte_count)) begin
            high_byte_hold_next = ctl.rx_byte;
          end
        end else if (CMP_W'(pos - RX_IDX_W'(1)) < CMP_W'(byte_count)) begin
          res.has_val = 1'b1;
          res.val     = {high_byte_hold, ctl.rx_byte};
        end
      end
      rx_index_next = rx_index + RX_IDX_W'(1);
    end

    if (rx_index_next < RX_IDX_W'(5)) begin
      res.status = ST_SHORT;
    end else if (exception_seen_next) begin
      res.status   = ST_EXCEPTION;
      res.exc_code = exception_hold_next;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear || (ctl.step && ctl.rx_final)) begin
      rx_index       <= '0;
      exception_seen <= 1'b0;
      byte_count     <= '0;
      high_byte_hold <= '0;
      exception_hold <= '0;
    end else if (ctl.step) begin
      rx_index       <= rx_index_next;
      exception_seen <= exception_seen_next;
      byte_count     <= byte_count_next;
      high_byte_hold <= high_byte_hold_next;
      exception_hold <= exception_hold_next;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    rx_index <= RX_IDX_W'(RX_MAX))
    else $error("response index past buffer limit");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.step && ctl.rx_final |=> rx_index == '0 && !exception_seen)
    else $error("response state not cleared after final byte");

  a_step_advances: assert property (@(posedge clk) disable iff (rst)
    ctl.step && !ctl.rx_final && !ctl.clear && rx_index < RX_IDX_W'(RX_MAX)
      |=> rx_index == $past(rx_index) + RX_IDX_W'(1))
    else $error("response index did not advance");

endmodule

`default_nettype wire

// ===== design/modbus_rtu_read_master_frame.sv =====
// Top level of the Modbus RTU read master: input register, result buffer
// and serializer. Depends on mbrm_pkg and mbrm_rx_parse.
//
// An input item is taken every cycle while the input register can drain.
// A request (action 0) yields the 8 request bytes from the result buffer,
// one per cycle while out_stall is low; the CRC-16/MODBUS is built a byte
// at a time as the header bytes leave. A response byte (action 1) yields
// none, one or two results (value, then status on the final byte); one
// that yields none passes even while earlier results are still being
// sent. The next item waits in the input register while the buffer still
// holds results.
`default_nettype none

module modbus_rtu_read_master_frame
  import mbrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  // Input register
  logic     s1_valid;
  in_item_t s1_item;

  // Result buffer
  logic        buf_valid;
  logic        buf_req;
  logic [7:0]  buf_slave;
  logic [7:0]  buf_func;
  logic [15:0] buf_addr;
  logic [15:0] buf_qty;
  logic        buf_has_val;
  logic [15:0] buf_val;
  logic [1:0]  buf_status;
  logic [7:0]  buf_exc;
  logic [2:0]  buf_ptr;
  logic [2:0]  buf_last;
  logic [15:0] crc;

  rx_ctl_t rx_ctl;
  rx_res_t rx_res;

  logic       in_fire, out_fire, buf_done, buf_free, no_result, adv;
  logic [7:0] tx_cur;

  mbrm_rx_parse u_rx_parse (
    .clk (clk),
    .rst (rst),
    .ctl (rx_ctl),
    .res (rx_res)
  );

  assign out_valid = buf_valid;
  assign out_fire  = buf_valid && !out_stall;
  assign buf_done  = out_fire && (buf_ptr == buf_last);
  assign buf_free  = !buf_valid || buf_done;
  assign no_result = (s1_item.action == ACT_RESPONSE) && !rx_res.has_val && !s1_item.rx_final;
  assign adv       = s1_valid && (no_result || buf_free);
  assign in_stall  = s1_valid && !adv;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    rx_ctl          = '0;
    rx_ctl.step     = adv && (s1_item.action == ACT_RESPONSE);
    rx_ctl.clear    = adv && (s1_item.action == ACT_REQUEST);
    rx_ctl.rx_byte  = s1_item.rx_byte;
    rx_ctl.rx_final = s1_item.rx_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
    end
  end

  always_comb begin
    case (buf_ptr)
      3'd0:    tx_cur = buf_slave;
      3'd1:    tx_cur = buf_func;
      3'd2:    tx_cur = buf_addr[15:8];
      3'd3:    tx_cur = buf_addr[7:0];
      3'd4:    tx_cur = buf_qty[15:8];
      3'd5:    tx_cur = buf_qty[7:0];
      3'd6:    tx_cur = crc[7:0];
      default: tx_cur = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_ptr   <= '0;
    end else if (adv && !no_result) begin
      buf_valid <= 1'b1;
      buf_ptr   <= '0;
    end else if (buf_done) begin
      buf_valid <= 1'b0;
    end else if (out_fire) begin
      buf_ptr <= buf_ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !no_result) begin
      buf_req     <= (s1_item.action == ACT_REQUEST);
      buf_slave   <= s1_item.slave_id;
      buf_func    <= s1_item.function_code;
      buf_addr    <= s1_item.start_address;
      buf_qty     <= s1_item.quantity;
      buf_has_val <= rx_res.has_val;
      buf_val     <= rx_res.val;
      buf_status  <= rx_res.status;
      buf_exc     <= rx_res.exc_code;
      crc         <= CRC_INIT;
      if (s1_item.action == ACT_REQUEST) begin
        buf_last <= 3'd7;
      end else begin
        buf_last <= (rx_res.has_val && s1_item.rx_final) ? 3'd1 : 3'd0;
      end
    end else if (out_fire && buf_req && buf_ptr < 3'd6) begin
      // fold each header byte into the CRC as it leaves
      crc <= crc_byte(crc, tx_cur);
    end
  end

  always_comb begin
    out_item      = '0;
    out_item.last = (buf_ptr == buf_last);
    if (buf_req) begin
      out_item.kind    = KIND_TX;
      out_item.tx_byte = tx_cur;
    end else if (buf_has_val && buf_ptr == 3'd0) begin
      out_item.kind      = KIND_VALUE;
      out_item.reg_value = buf_val;
    end else begin
      out_item.kind           = KIND_STATUS;
      out_item.status         = buf_status;
      out_item.exception_code = buf_exc;
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> buf_ptr <= buf_last)
    else $error("result pointer past last result");

  a_crc_start: assert property (@(posedge clk) disable iff (rst)
    buf_valid && buf_req && buf_ptr == 3'd0 |-> crc == CRC_INIT)
    else $error("CRC not seeded at request start");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && !buf_done && !(adv && !no_result)
      |=> buf_valid && buf_ptr == $past(buf_ptr) + 3'd1)
    else $error("result pointer did not advance on transfer");

  a_resp_count: assert property (@(posedge clk) disable iff (rst)
    buf_valid && !buf_req |-> buf_last <= 3'd1)
    else $error("response holds more than two results");

endmodule

`default_nettype wire

// ===== tb/sv/modbus_rtu_read_master_frame_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for modbus_rtu_read_master_frame: request framing with
// CRC-16/MODBUS and response parsing, checked against an in-bench scoreboard.
// Depends on mbrm_pkg and the RTL of the block.

module modbus_rtu_read_master_frame_tb;
  import mbrm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  class frame_scoreboard;
    out_item_t   expected_results[$];
    int          errors;
    int          rx_count;
    logic        exc_seen;
    logic [7:0]  byte_count;
    logic [7:0]  high_hold;
    logic [7:0]  exc_hold;

    function new();
      errors = 0;
      clear_response();
    endfunction

    function void clear_response();
      rx_count   = 0;
      exc_seen   = 1'b0;
      byte_count = 8'h00;
      high_hold  = 8'h00;
      exc_hold   = 8'h00;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] txb, logic [15:0] val,
                              logic [1:0] st, logic [7:0] exc, logic lst);
      out_item_t r;
      r.kind           = kind;
      r.tx_byte        = txb;
      r.reg_value      = val;
      r.status         = st;
      r.exception_code = exc;
      r.last           = lst;
      expected_results = {expected_results, r};
    endfunction

    // Predict the results of one accepted input item
    function void note_item(in_item_t it);
      logic [7:0]  frame [8];
      logic [15:0] crc;
      logic [7:0]  b;
      logic        have_val;
      logic [15:0] val;
      logic [1:0]  st;
      logic [7:0]  exc;
      int          p;
      if (it.action == ACT_REQUEST) begin
        frame[0] = it.slave_id;
        frame[1] = it.function_code;
        frame[2] = it.start_address[15:8];
        frame[3] = it.start_address[7:0];
        frame[4] = it.quantity[15:8];
        frame[5] = it.quantity[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) crc = crc_next(crc, frame[i]);
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        clear_response();
        for (int i = 0; i < 8; i++) push_result(KIND_TX, frame[i], 16'h0, ST_OK, 8'h0, i == 7);
      end else begin
        b = it.rx_byte;
        have_val = 1'b0;
        val = 16'h0;
        if (rx_count < RX_MAX) begin
          if (rx_count == 1) begin
            exc_seen = b[7];
          end else if (rx_count == 2) begin
            byte_count = b;
            exc_hold   = b;
          end else if (rx_count >= 3 && !exc_seen) begin
            p = rx_count - 3;
            if (p % 2 == 0) begin
              if (p < byte_count) high_hold = b;
            end else if (p - 1 < byte_count) begin
              val = {high_hold, b};
              have_val = 1'b1;
            end
          end
          rx_count++;
        end
        if (have_val) push_result(KIND_VALUE, 8'h0, val, ST_OK, 8'h0, !it.rx_final);
        if (it.rx_final) begin
          exc = 8'h0;
          if (rx_count < 5) begin
            st = ST_SHORT;
          end else if (exc_seen) begin
            st  = ST_EXCEPTION;
            exc = exc_hold;
          end else begin
            st = ST_OK;
          end
          push_result(KIND_STATUS, 8'h0, 16'h0, st, exc, 1'b1);
          clear_response();
        end
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t exp;
      string     diff;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp = expected_results.pop_front();
        diff = "";
        if (got.kind !== exp.kind) diff = {diff, " kind"};
        if (got.tx_byte !== exp.tx_byte) diff = {diff, " tx_byte"};
        if (got.reg_value !== exp.reg_value) diff = {diff, " reg_value"};
        if (got.status !== exp.status) diff = {diff, " status"};
        if (got.exception_code !== exp.exception_code) diff = {diff, " exception_code"};
        if (got.last !== exp.last) diff = {diff, " last"};
        if (diff != "") report($sformatf("field%s: got %h want %h", diff, got, exp));
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  frame_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  int cycle_count;
  int phase_items;

  modbus_rtu_read_master_frame uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.action        = 1'($urandom_range(0, 1));
    it.slave_id      = 8'($urandom);
    it.function_code = 8'($urandom);
    it.start_address = 16'($urandom);
    it.quantity      = 16'($urandom);
    it.rx_byte       = 8'($urandom);
    it.rx_final      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task send(in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    phase_items++;
  endtask

  task send_request(logic [7:0] sid, logic [7:0] fc, logic [15:0] addr, logic [15:0] qty);
    in_item_t it;
    it = random_item();
    it.action        = ACT_REQUEST;
    it.slave_id      = sid;
    it.function_code = fc;
    it.start_address = addr;
    it.quantity      = qty;
    send(it);
  endtask

  task send_random_request();
    send_request(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task send_byte(logic [7:0] b, logic fin);
    in_item_t it;
    it = random_item();
    it.action   = ACT_RESPONSE;
    it.rx_byte  = b;
    it.rx_final = fin;
    send(it);
  endtask

  // Optional request, then a well-formed response with random content, sometimes cut short or padded
  task send_frame();
    int         cnt;
    int         len;
    int         sel;
    logic [7:0] b;
    if ($urandom_range(0, 4) != 0) send_random_request();
    cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 9);
    len = cnt + 5;
    sel = $urandom_range(0, 5);
    if (sel == 0) len = $urandom_range(1, len);
    else if (sel == 1) len = len + $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 1) b[7] = ($urandom_range(0, 4) == 0);
      if (i == 2) b = 8'(cnt);
      send_byte(b, i == len - 1);
    end
  endtask

  // Drop valid, then hold off until every expected result has come
  task wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    phase_items = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: final byte with no frame, extreme and typical requests
    send_byte(8'hFF, 1'b1);
    send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
    send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(8'h11, 8'h03, 16'h006B, 16'h0003);
    // even count: two values, then ok
    send_byte(8'h11, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'hAE, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h52, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h40, 1'b1);
    // odd count: the last value completes on the final byte
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    // exception response one byte short, so reported as short
    send_byte(8'h01, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hC1, 1'b1);
    // short frame
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b1);
    wait_drained();

    // Frame running past the buffer
    send_random_request();
    for (int i = 0; i < RX_MAX + 6; i++) begin
      send_byte(i == 2 ? 8'hFF : 8'($urandom), i == RX_MAX + 5);
    end

    // Long receiver hold-off while requests keep coming, then pause until drained
    hold_cycles = 400;
    repeat (24) send_random_request();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      phase_items = 0;
      while (phase_items < 75) begin
        if ($urandom_range(0, 7) == 0) send(random_item());
        else send_frame();
      end
      @(negedge clk);
      in_valid = 1'b0;
      wait_drained();
    end

    stall_pct = 0;
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected results never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mbrm_pkg.sv
design/mbrm_rx_parse.sv
design/modbus_rtu_read_master_frame.sv
tb/sv/modbus_rtu_read_master_frame_tb.sv
